@@ rtl/swm_pkg.sv @@
// Shared constants and types of the sliding window median filter.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Default build values for the top-level parameters.
    localparam int DEF_MAX_RADIUS   = 8;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Radius register.
    localparam int          RADIUS_W     = 4;
    localparam logic [3:0]  RADIUS_RESET = 4'd1;

    // Per-cycle command broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic ins;     // insert the incoming sample
        logic del_en;  // drop the cell whose age matches the delete age
        logic clear;   // empty the chain after this cycle
    } t_chain_ctrl;

endpackage

`default_nettype wire

@@ rtl/swm_cell.sv @@
// One cell of the sorted sample chain: holds a sample, its age and a valid bit.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int SW = 16,
    parameter int AW = 5
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire swm_pkg::t_chain_ctrl i_ctrl,
    input  wire  [SW-1:0]            i_sample,
    input  wire  [AW-1:0]            i_del_age,
    // Raw contents of the neighbor above (higher index).
    input  wire  [SW-1:0]            i_up_value,
    input  wire                      i_up_valid,
    input  wire  [AW-1:0]            i_up_age,
    input  wire                      i_up_gt,
    // Deletion seen in some cell below this one.
    input  wire                      i_below,
    // Compacted contents of the neighbor below (lower index).
    input  wire  [SW-1:0]            i_dn_c_value,
    input  wire                      i_dn_c_valid,
    input  wire  [AW-1:0]            i_dn_c_age,
    input  wire                      i_dn_cg,
    output logic [SW-1:0]            o_value,
    output logic                     o_valid,
    output logic [AW-1:0]            o_age,
    output logic                     o_gt,
    output logic                     o_below,
    output logic [SW-1:0]            o_c_value,
    output logic                     o_c_valid,
    output logic [AW-1:0]            o_c_age,
    output logic                     o_cg
);
    import swm_pkg::*;

    logic [SW-1:0] r_value, n_value;
    logic          r_valid, n_valid;
    logic [AW-1:0] r_age,   n_age;
    logic          del_here;

    // This cell is the oldest one and is being dropped.
    assign del_here = i_ctrl.del_en && r_valid && (r_age == i_del_age);
    assign o_below  = i_below | del_here;

    // An empty cell sorts above any sample.
    assign o_gt = !r_valid || ($signed(r_value) > $signed(i_sample));

    // Contents after the dropped cell is squeezed out.
    assign o_c_value = o_below ? i_up_value : r_value;
    assign o_c_valid = o_below ? i_up_valid : r_valid;
    assign o_c_age   = o_below ? i_up_age   : r_age;
    assign o_cg      = o_below ? i_up_gt    : o_gt;

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_age   = r_age;

    // Next contents: shift up from below, take new sample, close gap from above, keep or clear.
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        n_age   = r_age;
        if (i_ctrl.ins) begin
            if (i_dn_cg) begin
                n_value = i_dn_c_value;
                n_valid = i_dn_c_valid;
                n_age   = i_dn_c_age + AW'(1);
            end else if (o_cg) begin
                n_value = i_sample;
                n_valid = 1'b1;
                n_age   = '0;
            end else begin
                n_value = o_c_value;
                n_valid = o_c_valid;
                n_age   = o_c_age + AW'(1);
            end
        end else if (i_ctrl.del_en) begin
            n_value = o_c_value;
            n_valid = o_c_valid;
            n_age   = o_c_age;
        end
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end
    end

    // Sample and age are payload; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

@@ rtl/swm_chain.sv @@
// Row of sorted cells holding the current window, smallest sample in cell 0.
`timescale 1ns / 1ps
`default_nettype none

module swm_chain #(
    parameter int SW    = 16,
    parameter int DEPTH = 17,
    parameter int AW    = 5
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire swm_pkg::t_chain_ctrl i_ctrl,
    input  wire  [SW-1:0]            i_sample,
    input  wire  [AW-1:0]            i_del_age,
    input  wire  [AW-1:0]            i_sel,
    output logic [SW-1:0]            o_median
);
    import swm_pkg::*;

    logic [SW-1:0] value   [DEPTH];
    logic          valid   [DEPTH];
    logic [AW-1:0] age     [DEPTH];
    logic          gt      [DEPTH];
    logic          below   [DEPTH+1];
    logic [SW-1:0] c_value [DEPTH];
    logic          c_valid [DEPTH];
    logic [AW-1:0] c_age   [DEPTH];
    logic          cg      [DEPTH];

    assign below[0] = 1'b0;

    // Each cell talks to its two neighbors; the top end sees an empty cell.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [SW-1:0] up_value;
        logic          up_valid;
        logic [AW-1:0] up_age;
        logic          up_gt;
        logic [SW-1:0] dn_value;
        logic          dn_valid;
        logic [AW-1:0] dn_age;
        logic          dn_cg;

        if (i == DEPTH - 1) begin : g_top
            assign up_value = '0;
            assign up_valid = 1'b0;
            assign up_age   = '0;
            assign up_gt    = 1'b1;
        end else begin : g_mid
            assign up_value = value[i+1];
            assign up_valid = valid[i+1];
            assign up_age   = age[i+1];
            assign up_gt    = gt[i+1];
        end

        if (i == 0) begin : g_bot
            assign dn_value = '0;
            assign dn_valid = 1'b0;
            assign dn_age   = '0;
            assign dn_cg    = 1'b0;
        end else begin : g_low
            assign dn_value = c_value[i-1];
            assign dn_valid = c_valid[i-1];
            assign dn_age   = c_age[i-1];
            assign dn_cg    = cg[i-1];
        end

        swm_cell #(
            .SW (SW),
            .AW (AW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_sample     (i_sample),
            .i_del_age    (i_del_age),
            .i_up_value   (up_value),
            .i_up_valid   (up_valid),
            .i_up_age     (up_age),
            .i_up_gt      (up_gt),
            .i_below      (below[i]),
            .i_dn_c_value (dn_value),
            .i_dn_c_valid (dn_valid),
            .i_dn_c_age   (dn_age),
            .i_dn_cg      (dn_cg),
            .o_value      (value[i]),
            .o_valid      (valid[i]),
            .o_age        (age[i]),
            .o_gt         (gt[i]),
            .o_below      (below[i+1]),
            .o_c_value    (c_value[i]),
            .o_c_valid    (c_valid[i]),
            .o_c_age      (c_age[i]),
            .o_cg         (cg[i])
        );
    end

    // The median is the cell at rank radius.
    assign o_median = value[i_sel];

endmodule

`default_nettype wire

@@ rtl/swm_out.sv @@
// Result sequencer and output register: at most one median or edge zero, then zeros.
`timescale 1ns / 1ps
`default_nettype none

module swm_out #(
    parameter int SW = 16,
    parameter int ZW = 4
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_load,
    input  wire           i_main,
    input  wire           i_edge,
    input  wire  [ZW-1:0] i_zeros,
    input  wire  [SW-1:0] i_median,
    output logic          o_can_take,
    output logic          o_tvalid,
    input  wire           i_tready,
    output logic [SW-1:0] o_value,
    output logic          o_edge,
    output logic          o_end
);
    import swm_pkg::*;

    logic          r_main;
    logic          r_edge;
    logic [ZW-1:0] r_zeros;
    logic          r_ovalid;
    logic [SW-1:0] r_value;
    logic          r_oedge;
    logic          r_end;
    logic          out_free;
    logic          pend_any;
    logic          pend_one;
    logic          step;

    assign out_free = !r_ovalid || i_tready;
    assign pend_any = r_main || (r_zeros != '0);
    assign pend_one = (r_main && (r_zeros == '0)) || (!r_main && (r_zeros == ZW'(1)));
    assign step     = out_free && pend_any;

    // A new item may enter once the last pending result moves out this cycle.
    assign o_can_take = !pend_any || (out_free && pend_one);

    // Pending work of the item in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main  <= 1'b0;
            r_edge  <= 1'b0;
            r_zeros <= '0;
        end else begin
            if (step) begin
                if (r_main) begin
                    r_main <= 1'b0;
                end else begin
                    r_zeros <= r_zeros - ZW'(1);
                end
            end
            if (i_load) begin
                r_main  <= i_main;
                r_edge  <= i_edge;
                r_zeros <= i_zeros;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= pend_any;
        end
        if (step) begin
            if (r_main) begin
                r_value <= r_edge ? '0 : i_median;
                r_oedge <= r_edge;
                r_end   <= (r_zeros == '0);
            end else begin
                r_value <= '0;
                r_oedge <= 1'b1;
                r_end   <= (r_zeros == ZW'(1));
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_value  = r_value;
    assign o_edge   = r_oedge;
    assign o_end    = r_end;

endmodule

`default_nettype wire

@@ rtl/sliding_window_median.sv @@
// Top level of the streaming sliding window median filter.
`timescale 1ns / 1ps
`default_nettype none

// The filter outputs, for each sample position, the median of the 2*radius+1
// samples centered on it, and an edge zero (tuser high) for the first and last
// radius positions of a stream. The sample with tlast set also releases the
// trailing edge zeros, so a stream of L samples gives L results; tlast on a
// result marks the final one caused by an input transfer. The window lives in
// a chain of sorted cells that drops its oldest sample and inserts the new one
// together, so one sample is taken per clock unless pruning or busy; a transfer
// without tlast yields at most one result. A sample with tlast causes up to 1 +
// radius results, one per cycle while m_axis_tready is high, through the single
// output register, and the next transfer is taken in the cycle its final result
// moves out. Output tvalid rises once the transfer has passed the pending-work
// and then the free output register. After radius is lowered the chain sheds
// one surplus sample per cycle before the next transfer is taken. Radius values
// above MAX_RADIUS act as MAX_RADIUS; radius zero passes samples through.
module sliding_window_median #(
    parameter int MAX_RADIUS   = swm_pkg::DEF_MAX_RADIUS,
    parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH,
    localparam int TW          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Radius register write.
    input  wire                          i_cfg_we,
    input  wire  [swm_pkg::RADIUS_W-1:0] i_cfg_wdata,
    // Input stream.
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [TW-1:0]                s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample, rest unused
    input  wire                          s_axis_tlast,
    // Result stream.
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [TW-1:0]                m_axis_tdata,  // [SAMPLE_WIDTH-1:0] value, rest zero
    output logic                         m_axis_tuser,  // [0] edge_res
    output logic                         m_axis_tlast
);
    import swm_pkg::*;

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int ZW    = $clog2(MAX_RADIUS + 1);

    logic [RADIUS_W-1:0]     r_radius;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [CW-1:0]           r_eff;
    logic [CW-1:0]           win;
    logic [CW-1:0]           count_new;
    logic                    prune;
    logic                    accept;
    logic                    can_take;
    logic                    main_res;
    logic                    edge_flag;
    logic [ZW-1:0]           zeros;
    t_chain_ctrl             ctrl;
    logic [SAMPLE_WIDTH-1:0] median;
    logic [SAMPLE_WIDTH-1:0] out_value;

    // Radius register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // Effective radius and window size.
    always_comb begin
        if (32'(r_radius) > 32'(MAX_RADIUS)) begin
            r_eff = CW'(MAX_RADIUS);
        end else begin
            r_eff = CW'(r_radius);
        end
    end
    assign win = {r_eff[CW-2:0], 1'b1};

    // The chain holds more samples than the window after radius is lowered.
    assign prune         = r_count > win;
    assign s_axis_tready = !prune && can_take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign count_new = (r_count == win) ? win : r_count + CW'(1);

    // Results caused by this transfer.
    assign main_res  = count_new > r_eff;
    assign edge_flag = count_new < win;
    always_comb begin
        zeros = '0;
        if (s_axis_tlast) begin
            zeros = (count_new < r_eff) ? ZW'(count_new) : ZW'(r_eff);
        end
    end

    // Chain commands.
    always_comb begin
        ctrl.ins    = accept;
        ctrl.del_en = (accept && (r_count == win)) || prune;
        ctrl.clear  = accept && s_axis_tlast;
    end

    // Chain fill level.
    always_comb begin
        n_count = r_count;
        if (prune) begin
            n_count = r_count - CW'(1);
        end else if (accept) begin
            n_count = s_axis_tlast ? '0 : count_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    swm_chain #(
        .SW    (SAMPLE_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_del_age (AW'(r_count - CW'(1))),
        .i_sel     (AW'(r_eff)),
        .o_median  (median)
    );

    swm_out #(
        .SW (SAMPLE_WIDTH),
        .ZW (ZW)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_main     (main_res),
        .i_edge     (edge_flag),
        .i_zeros    (zeros),
        .i_median   (median),
        .o_can_take (can_take),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_value    (out_value),
        .o_edge     (m_axis_tuser),
        .o_end      (m_axis_tlast)
    );

    assign m_axis_tdata = TW'(out_value);

endmodule

`default_nettype wire
